@@ design/mic_pkg.sv @@
// Package for magnetometer iron correction: field widths, register indexes,
// shared types and reset values. No dependencies.

package mic_pkg;

   localparam int RAW_W    = 16;
   localparam int RANGE_W  = 2;
   localparam int SCALED_W = 21;
   localparam int BIAS_W   = 22;
   localparam int DIFF_W   = 23;
   localparam int COEFF_W  = 18;
   localparam int ROW_W    = 3 * COEFF_W;
   localparam int PROD_W   = COEFF_W + DIFF_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int FRAC_W   = 16;
   localparam int SHIFT_W  = SUM_W - FRAC_W;
   localparam int OUT_W    = 24;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [SHIFT_W-1:0] OUT_MAX = SHIFT_W'(8388607);
   localparam logic signed [SHIFT_W-1:0] OUT_MIN = -SHIFT_W'(8388608);

   // identity matrix after reset
   localparam logic [ROW_W-1:0] ROW_X_RESET = ROW_W'(1) << 16;
   localparam logic [ROW_W-1:0] ROW_Y_RESET = ROW_W'(1) << 34;
   localparam logic [ROW_W-1:0] ROW_Z_RESET = ROW_W'(1) << 52;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_CODE = 3'd0,
      CSR_BIAS_X     = 3'd1,
      CSR_BIAS_Y     = 3'd2,
      CSR_BIAS_Z     = 3'd3,
      CSR_ROW_X      = 3'd4,
      CSR_ROW_Y      = 3'd5,
      CSR_ROW_Z      = 3'd6
   } csr_index_type;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef diff_type diff_vec_type [3];

   // load enables of the three back stages, driven by the top level
   typedef struct packed {
      logic mul_en;
      logic sum_en;
      logic sat_en;
   } pipe_ctl_type;

endpackage

@@ design/mic_row.sv @@
// One matrix row: three products, row sum, floor shift and 24-bit clip.
// Depends on mic_pkg; stage enables come from the top-level valid chain.

module mic_row
   import mic_pkg::*;
(
   input  logic                     clock,
   input  pipe_ctl_type             ctl,
   input  diff_vec_type             diff,
   input  logic [ROW_W-1:0]         coeff_row,
   output logic signed [OUT_W-1:0]  corrected,
   output logic                     clipped
);

   logic signed [COEFF_W-1:0] coeff [3];
   logic signed [PROD_W-1:0]  prod_in [3];
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SHIFT_W-1:0] shifted;
   logic signed [OUT_W-1:0]   corrected_in;
   logic signed [OUT_W-1:0]   corrected_ff;
   logic                      clipped_in;
   logic                      clipped_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         coeff[j]   = coeff_row[COEFF_W*j +: COEFF_W];
         prod_in[j] = coeff[j] * diff[j];
      end
   end

   always_comb begin
      sum_in = {{2{prod_ff[0][PROD_W-1]}}, prod_ff[0]}
             + {{2{prod_ff[1][PROD_W-1]}}, prod_ff[1]}
             + {{2{prod_ff[2][PROD_W-1]}}, prod_ff[2]};
   end

   // arithmetic shift by dropping fraction bits rounds toward minus infinity
   assign shifted = sum_ff[SUM_W-1:FRAC_W];

   always_comb begin
      priority if (shifted > OUT_MAX) begin
         corrected_in = OUT_MAX[OUT_W-1:0];
         clipped_in   = 1'b1;
      end else if (shifted < OUT_MIN) begin
         corrected_in = OUT_MIN[OUT_W-1:0];
         clipped_in   = 1'b1;
      end else begin
         corrected_in = shifted[OUT_W-1:0];
         clipped_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
      if (ctl.sat_en) begin
         corrected_ff <= corrected_in;
         clipped_ff   <= clipped_in;
      end
   end

   assign corrected = corrected_ff;
   assign clipped   = clipped_ff;

endmodule

@@ design/magnetometer_iron_correction.sv @@
// Top level of magnetometer hard/soft iron correction: config registers,
// scaling and bias stages, valid chain. Depends on mic_pkg and mic_row.
//
//   channel | ports            | direction | transaction
//   --------+------------------+-----------+-------------------------------
//   req     | req_valid/ready  | in        | one raw x/y/z sample
//   rsp     | rsp_valid/ready  | out       | scaled and corrected field
//   csr     | csr_wr_en        | in        | one register write, no wait
//
// Five register stages: scale, bias subtract, products, row sum, clip.
// One sample per cycle sustained while rsp_ready stays high; the accepting
// edge loads the scale stage, and rsp_valid rises as the clip stage loads.
// Each stage holds its own valid bit; a stage loads when it is empty or
// the stage after it moves, so bubbles close up behind a stalled output.
// Synchronous reset clears the valid bits and restores the register
// defaults (range code 0, zero bias, identity matrix).

module magnetometer_iron_correction
   import mic_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [ROW_W-1:0]            csr_wdata,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [RAW_W-1:0]     req_raw_x,
   input  logic signed [RAW_W-1:0]     req_raw_y,
   input  logic signed [RAW_W-1:0]     req_raw_z,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SCALED_W-1:0]  rsp_scaled_x,
   output logic signed [SCALED_W-1:0]  rsp_scaled_y,
   output logic signed [SCALED_W-1:0]  rsp_scaled_z,
   output logic signed [OUT_W-1:0]     rsp_corrected_x,
   output logic signed [OUT_W-1:0]     rsp_corrected_y,
   output logic signed [OUT_W-1:0]     rsp_corrected_z,
   output logic                        rsp_saturated
);

   localparam int STAGES = 5;

   // ---------------- configuration registers ----------------
   logic [RANGE_W-1:0]        range_code_ff;
   logic signed [BIAS_W-1:0]  bias_ff [3];
   logic [ROW_W-1:0]          row_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         range_code_ff <= '0;
         bias_ff[0]    <= '0;
         bias_ff[1]    <= '0;
         bias_ff[2]    <= '0;
         row_ff[0]     <= ROW_X_RESET;
         row_ff[1]     <= ROW_Y_RESET;
         row_ff[2]     <= ROW_Z_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_RANGE_CODE: range_code_ff <= csr_wdata[RANGE_W-1:0];
            CSR_BIAS_X:     bias_ff[0]    <= csr_wdata[BIAS_W-1:0];
            CSR_BIAS_Y:     bias_ff[1]    <= csr_wdata[BIAS_W-1:0];
            CSR_BIAS_Z:     bias_ff[2]    <= csr_wdata[BIAS_W-1:0];
            CSR_ROW_X:      row_ff[0]     <= csr_wdata;
            CSR_ROW_Y:      row_ff[1]     <= csr_wdata;
            CSR_ROW_Z:      row_ff[2]     <= csr_wdata;
            default: ;      // unused index, write dropped
         endcase
      end
   end

   // ---------------- valid chain ----------------
   // stage k (0..4) loads when empty or when stage k+1 loads / output drains
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] load;

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES-2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in = valid_ff;
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // ---------------- stage 0: scale raw counts ----------------
   // raw * (range_code + 1) fits 18 bits; times 8 is a three-bit shift.
   logic [2:0]                  mult;
   logic signed [RAW_W-1:0]     raw [3];
   logic signed [RAW_W+3:0]     raw_mul [3];
   logic signed [SCALED_W-1:0]  scaled_in [3];
   logic signed [SCALED_W-1:0]  scaled0_ff [3];

   assign mult   = {1'b0, range_code_ff} + 3'd1;
   assign raw[0] = req_raw_x;
   assign raw[1] = req_raw_y;
   assign raw[2] = req_raw_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         raw_mul[i]   = raw[i] * $signed({1'b0, mult});
         scaled_in[i] = {raw_mul[i][17:0], 3'b000};
      end
   end

   // ---------------- stage 1: hard-iron bias ----------------
   diff_vec_type                diff_in;
   diff_vec_type                diff_ff;
   logic signed [SCALED_W-1:0]  scaled1_ff [3];
   logic signed [SCALED_W-1:0]  scaled2_ff [3];
   logic signed [SCALED_W-1:0]  scaled3_ff [3];
   logic signed [SCALED_W-1:0]  scaled4_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = {{2{scaled0_ff[i][SCALED_W-1]}}, scaled0_ff[i]}
                    - {bias_ff[i][BIAS_W-1], bias_ff[i]};
      end
   end

   // scaled values ride along with the row pipeline
   always_ff @(posedge clock) begin
      if (load[0]) begin
         scaled0_ff <= scaled_in;
      end
      if (load[1]) begin
         scaled1_ff <= scaled0_ff;
         diff_ff    <= diff_in;
      end
      if (load[2]) begin
         scaled2_ff <= scaled1_ff;
      end
      if (load[3]) begin
         scaled3_ff <= scaled2_ff;
      end
      if (load[4]) begin
         scaled4_ff <= scaled3_ff;
      end
   end

   // ---------------- stages 2..4: soft-iron matrix ----------------
   pipe_ctl_type               row_ctl;
   logic signed [OUT_W-1:0]    corrected [3];
   logic [2:0]                 clipped;

   assign row_ctl.mul_en = load[2];
   assign row_ctl.sum_en = load[3];
   assign row_ctl.sat_en = load[4];

   for (genvar r = 0; r < 3; r++) begin : g_row
      mic_row u_row (
         .clock     (clock),
         .ctl       (row_ctl),
         .diff      (diff_ff),
         .coeff_row (row_ff[r]),
         .corrected (corrected[r]),
         .clipped   (clipped[r])
      );
   end

   // ---------------- result ----------------
   assign rsp_scaled_x    = scaled4_ff[0];
   assign rsp_scaled_y    = scaled4_ff[1];
   assign rsp_scaled_z    = scaled4_ff[2];
   assign rsp_corrected_x = corrected[0];
   assign rsp_corrected_y = corrected[1];
   assign rsp_corrected_z = corrected[2];
   assign rsp_saturated   = |clipped;

endmodule
